FILE: design/kvlit_pkg.sv
// ----------------------------------------------------------------------------
// kvlit_pkg
// shared widths, status codes and default table size for the lookup table
// ----------------------------------------------------------------------------
package kvlit_pkg;

	localparam int KEY_W      = 64;
	localparam int VALUE_W    = 64;
	localparam int SLOT_W     = 5;
	localparam int STATUS_W   = 2;
	localparam int DEF_MAX_ENTRIES = 16;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_FOUND    = 2'd0;
	localparam status_t ST_INSERTED = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;
	localparam status_t ST_NULLKEY  = 2'd3;

endpackage

FILE: design/keyed_value_lookup_insert_table.sv
// ----------------------------------------------------------------------------
// keyed_value_lookup_insert_table
// lookup-or-insert table: linear key search in a synchronous key memory,
// values in a second memory with one shared overflow slot
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ---------------------------------
//  in       in   in_valid / in_ready  op, key, write_value
//  out      out  out_valid/ out_ready read_value, slot, status
//
// a null key item goes straight to its result; a hit in slot i searches slots 0
// to i (one more step for a get), a miss searches every filled slot (one more step
// for an overflow get); the key memory read port, one entry per cycle, sets the search length
// items are taken one at a time; the result register lets the next item in
// while a result waits; a full result register holds the item in its last step
// no clearing pass after reset: key slots are only read below the fill count,
// and the overflow value reads as zero until first written
//
module keyed_value_lookup_insert_table #(
	parameter int MAX_ENTRIES = kvlit_pkg::DEF_MAX_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic [kvlit_pkg::KEY_W-1:0]      key,
	input  logic [kvlit_pkg::VALUE_W-1:0]    write_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [kvlit_pkg::VALUE_W-1:0]    read_value,
	output logic [kvlit_pkg::SLOT_W-1:0]     slot,
	output logic [kvlit_pkg::STATUS_W-1:0]   status
);
	import kvlit_pkg::*;

	localparam int KIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int VIW = CW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_MISS,
		S_VREAD,
		S_DONE
	} state_t;

	state_t state_q;

	logic [KEY_W-1:0]   key_mem [MAX_ENTRIES];
	logic [VALUE_W-1:0] val_mem [MAX_ENTRIES+1];

	logic [KEY_W-1:0]   key_rd_q;
	logic [VALUE_W-1:0] val_rd_q;

	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] wval_q;
	logic [KIW-1:0]     cmp_idx_q;
	logic [CW-1:0]      fill_q;
	logic               ovf_written_q;

	logic [VALUE_W-1:0] res_value_q;
	logic [SLOT_W-1:0]  res_slot_q;
	status_t            res_status_q;

	logic               accept;
	logic               hit;
	logic               last;
	logic               room;
	logic               key_re;
	logic [KIW-1:0]     key_raddr;
	logic               key_we;
	logic               val_re;
	logic [VIW-1:0]     val_raddr;
	logic               val_we;
	logic [VIW-1:0]     val_waddr;
	logic [VALUE_W-1:0] val_wdata;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign hit      = (key_rd_q == key_q);
	assign last     = ((CW'(cmp_idx_q) + CW'(1)) == fill_q);
	assign room     = (fill_q < CW'(MAX_ENTRIES));

	// key memory read: slot 0 on accept of a non-null key into a nonempty table, then one slot per cycle
	always_comb begin
		key_re    = 1'b0;
		key_raddr = cmp_idx_q + KIW'(1);
		if (accept && key != '0 && fill_q != '0) begin
			key_re    = 1'b1;
			key_raddr = '0;
		end else if (state_q == S_SEARCH && !hit && !last) begin
			key_re = 1'b1;
		end
	end

	assign key_we = (state_q == S_MISS) && room;

	// value memory accesses
	always_comb begin
		val_re    = 1'b0;
		val_raddr = VIW'(cmp_idx_q);
		val_we    = 1'b0;
		val_waddr = VIW'(cmp_idx_q);
		val_wdata = wval_q;
		if (state_q == S_SEARCH && hit) begin
			val_re = !op_q;
			val_we = op_q;
		end else if (state_q == S_MISS) begin
			if (room) begin
				// a new slot starts at zero unless this item sets it
				val_we    = 1'b1;
				val_waddr = VIW'(fill_q);
				val_wdata = op_q ? wval_q : '0;
			end else begin
				val_re    = !op_q;
				val_raddr = VIW'(MAX_ENTRIES);
				val_we    = op_q;
				val_waddr = VIW'(MAX_ENTRIES);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_re) begin
			key_rd_q <= key_mem[key_raddr];
		end
		if (key_we) begin
			key_mem[fill_q[KIW-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (val_re) begin
			val_rd_q <= val_mem[val_raddr];
		end
		if (val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op;
			key_q     <= key;
			wval_q    <= write_value;
			cmp_idx_q <= '0;
		end else if (state_q == S_SEARCH && !hit && !last) begin
			cmp_idx_q <= cmp_idx_q + KIW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			ovf_written_q <= 1'b0;
			res_value_q   <= '0;
			res_slot_q    <= '0;
			res_status_q  <= ST_FOUND;
			out_valid     <= 1'b0;
			read_value    <= '0;
			slot          <= '0;
			status        <= ST_FOUND;
		end else begin
			if (state_q == S_DONE && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (key == '0) begin
							res_value_q  <= '0;
							res_slot_q   <= '0;
							res_status_q <= ST_NULLKEY;
							state_q      <= S_DONE;
						end else if (fill_q == '0) begin
							state_q <= S_MISS;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						res_slot_q   <= SLOT_W'(cmp_idx_q);
						res_status_q <= ST_FOUND;
						res_value_q  <= wval_q;
						state_q      <= op_q ? S_DONE : S_VREAD;
					end else if (last) begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (room) begin
						res_slot_q   <= SLOT_W'(fill_q);
						res_status_q <= ST_INSERTED;
						res_value_q  <= op_q ? wval_q : '0;
						fill_q       <= fill_q + CW'(1);
						state_q      <= S_DONE;
					end else begin
						res_slot_q   <= SLOT_W'(MAX_ENTRIES);
						res_status_q <= ST_OVERFLOW;
						res_value_q  <= wval_q;
						if (op_q) begin
							ovf_written_q <= 1'b1;
						end
						state_q <= op_q ? S_DONE : S_VREAD;
					end
				end
				S_VREAD: begin
					// overflow value reads as zero until first set
					if (res_status_q == ST_OVERFLOW && !ovf_written_q) begin
						res_value_q <= '0;
					end else begin
						res_value_q <= val_rd_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						read_value <= res_value_q;
						slot       <= res_slot_q;
						status     <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_ENTRIES))
		else $error("fill count beyond table size");

	a_search_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> CW'(cmp_idx_q) < fill_q)
		else $error("search read past filled slots");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MISS && room) |=> fill_q == $past(fill_q) + CW'(1))
		else $error("insert did not advance fill count");

	a_null_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NULLKEY) |-> (read_value == '0 && slot == '0))
		else $error("null key item with nonzero result");

	a_ovf_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OVERFLOW) |-> (slot == SLOT_W'(MAX_ENTRIES) && !room))
		else $error("overflow result while table has room");

endmodule

FILE: tb/tb_keyed_value_lookup_insert_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_value_lookup_insert_table
// self-checking bench for the lookup-or-insert table: a directed opening fills
// the table and walks the null-key, insert, hit and overflow cases, then
// random requests mix hits, unknown keys, null keys and set/get pairs; each
// result is checked in order against a behavioral model of the table
// ----------------------------------------------------------------------------
module tb_keyed_value_lookup_insert_table;

	import kvlit_pkg::*;

	localparam int          TABLE_DEPTH  = DEF_MAX_ENTRIES;
	localparam logic        OP_GET       = 1'b0;
	localparam logic        OP_SET       = 1'b1;
	localparam int          RANDOM_ITEMS = 1375;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          CYCLE_LIMIT  = 800000;
	localparam logic [KEY_W-1:0] NULL_KEY = '0;

	typedef struct packed {
		logic               op;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] write_value;
	} request_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [SLOT_W-1:0]  slot;
		status_t            status;
	} lookup_reply_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               op          = OP_GET;
	logic [KEY_W-1:0]   key         = '0;
	logic [VALUE_W-1:0] write_value = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [VALUE_W-1:0] read_value;
	logic [SLOT_W-1:0]  slot;
	logic [STATUS_W-1:0] status;

	// model state of the table
	logic [KEY_W-1:0]   model_keys [TABLE_DEPTH];
	logic [VALUE_W-1:0] model_values [TABLE_DEPTH+1];
	int                 model_fill = 0;

	request_t       request_queue [$];
	lookup_reply_t  lookup_replies [$];
	logic [KEY_W-1:0] table_keys [$];
	logic [KEY_W-1:0] stray_keys [4];

	int unsigned total_requests = 0;
	int unsigned n_accepted     = 0;
	int unsigned n_checked      = 0;
	int unsigned fail_count     = 0;
	int unsigned status_seen [4] = '{0, 0, 0, 0};
	int unsigned cycle_count    = 0;
	int unsigned send_gap       = 0;
	int unsigned recv_gap       = 0;
	logic        hold_off       = 1'b0;

	keyed_value_lookup_insert_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.key         (key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value),
		.slot        (slot),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		for (int i = 0; i <= TABLE_DEPTH; i++)
			model_values[i] = '0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			model_keys[i] = '0;
	end

	function automatic lookup_reply_t lookup_or_insert(input request_t req);
		lookup_reply_t rep;
		int            idx;
		bit            hit;
		hit = 1'b0;
		idx = 0;
		if (req.key == NULL_KEY) begin
			rep.value  = '0;
			rep.slot   = '0;
			rep.status = ST_NULLKEY;
			return rep;
		end
		for (int i = 0; i < model_fill; i++)
			if (!hit && model_keys[i] == req.key) begin
				idx = i;
				hit = 1'b1;
			end
		if (hit) begin
			rep.status = ST_FOUND;
		end else if (model_fill < TABLE_DEPTH) begin
			idx = model_fill;
			model_keys[idx] = req.key;
			model_values[idx] = '0;
			model_fill++;
			rep.status = ST_INSERTED;
		end else begin
			idx = TABLE_DEPTH;
			rep.status = ST_OVERFLOW;
		end
		if (req.op == OP_SET)
			model_values[idx] = req.write_value;
		rep.value = model_values[idx];
		rep.slot  = SLOT_W'(idx);
		return rep;
	endfunction

	// mostly short gaps, a few long ones, and stretches with none at all
	function automatic int unsigned pick_gap(input int unsigned served);
		int unsigned roll;
		if ((served / 150) % 4 == 2)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_request(input logic o, input logic [KEY_W-1:0] k,
	                           input logic [VALUE_W-1:0] v);
		request_t r;
		r.op = o;
		r.key = k;
		r.write_value = v;
		request_queue.push_back(r);
		total_requests++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return rand64();
	endfunction

	function automatic logic [KEY_W-1:0] rand_new_key();
		logic [KEY_W-1:0] k;
		k = rand64();
		if (k == NULL_KEY)
			k = 64'h1;
		return k;
	endfunction

	// driver: offer the next item once the current one is taken
	always @(posedge clk or negedge arst_n) begin : driver
		request_t nxt;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			op          <= OP_GET;
			key         <= '0;
			write_value <= '0;
			send_gap    <= 0;
		end else begin
			if (in_valid && in_ready) begin
				nxt.op = op;
				nxt.key = key;
				nxt.write_value = write_value;
				lookup_replies.push_back(lookup_or_insert(nxt));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					nxt = request_queue.pop_front();
					op          <= nxt.op;
					key         <= nxt.key;
					write_value <= nxt.write_value;
					in_valid    <= 1'b1;
					send_gap    <= pick_gap(n_accepted);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result in order, stall at random
	always @(posedge clk or negedge arst_n) begin : monitor
		lookup_reply_t exp_rep;
		int unsigned   g;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (lookup_replies.size() == 0) begin
					$error("result with no item pending: read_value %h slot %0d status %0d",
					       read_value, slot, status);
					fail_count++;
				end else begin
					exp_rep = lookup_replies.pop_front();
					if (read_value !== exp_rep.value) begin
						$error("read_value mismatch: expected %h, got %h",
						       exp_rep.value, read_value);
						fail_count++;
					end
					if (slot !== exp_rep.slot) begin
						$error("slot mismatch: expected %0d, got %0d", exp_rep.slot, slot);
						fail_count++;
					end
					if (status !== exp_rep.status) begin
						$error("status mismatch: expected %0d, got %0d",
						       exp_rep.status, status);
						fail_count++;
					end
					status_seen[exp_rep.status]++;
				end
				n_checked++;
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				g = pick_gap(n_checked);
				recv_gap  <= g;
				out_ready <= (g == 0);
			end else if (recv_gap > 1) begin
				recv_gap  <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				recv_gap  <= 0;
				out_ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	initial begin
		wait (n_accepted >= 500);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items pending", cycle_count,
			         lookup_replies.size());
			$display("FAIL keyed_value_lookup_insert_table");
			$finish;
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0]   k;
		logic [VALUE_W-1:0] v;
		int unsigned        roll;

		// null key, both ops, value field all ones
		add_request(OP_GET, NULL_KEY, '1);
		add_request(OP_SET, NULL_KEY, '1);
		// insert by get, then hit with set and get
		add_request(OP_GET, 64'h1, '0);
		add_request(OP_SET, 64'h1, '1);
		add_request(OP_GET, 64'h1, '0);
		table_keys.push_back(64'h1);
		// all-ones key inserted by a set of zero
		add_request(OP_SET, '1, '0);
		add_request(OP_GET, '1, '1);
		table_keys.push_back('1);
		// fill the rest of the table
		add_request(OP_SET, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
		table_keys.push_back(64'h8000_0000_0000_0000);
		while (table_keys.size() < TABLE_DEPTH) begin
			k = rand_new_key();
			add_request(1'($urandom_range(0, 1)), k, rand64());
			table_keys.push_back(k);
		end
		// table full: unknown keys share the overflow value, then a set hits key 1
		for (int i = 0; i < 4; i++)
			stray_keys[i] = rand_new_key();
		add_request(OP_GET, stray_keys[0], '1);
		add_request(OP_SET, stray_keys[1], 64'h5a5a_a5a5_0f0f_f0f0);
		add_request(OP_GET, stray_keys[2], '0);
		add_request(OP_SET, 64'h1, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			v = rand_value();
			if (roll < 45) begin
				k = table_keys[$urandom_range(0, TABLE_DEPTH - 1)];
				add_request(1'($urandom_range(0, 1)), k, v);
			end else if (roll < 65) begin
				// set then read back the same key
				k = ($urandom_range(0, 2) == 0) ? stray_keys[$urandom_range(0, 3)]
				                                : table_keys[$urandom_range(0, TABLE_DEPTH - 1)];
				add_request(OP_SET, k, v);
				add_request(OP_GET, k, rand64());
				n++;
			end else if (roll < 80) begin
				add_request(1'($urandom_range(0, 1)), rand_new_key(), v);
			end else if (roll < 88) begin
				add_request(1'($urandom_range(0, 1)), stray_keys[$urandom_range(0, 3)], v);
			end else if (roll < 94) begin
				add_request(1'($urandom_range(0, 1)), NULL_KEY, v);
			end else begin
				// single-bit and single-hole keys
				k = 64'h1 << $urandom_range(0, KEY_W - 1);
				if ($urandom_range(0, 1))
					k = ~k;
				add_request(1'($urandom_range(0, 1)), k, v);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == total_requests);
		wait (lookup_replies.size() == 0);
		repeat (40) @(posedge clk);

		$display("%0d items checked: %0d hits, %0d inserts, %0d overflow, %0d null key",
		         n_checked, status_seen[ST_FOUND], status_seen[ST_INSERTED],
		         status_seen[ST_OVERFLOW], status_seen[ST_NULLKEY]);
		$display("random stalls on both sides plus a %0d-cycle receiver hold-off",
		         HOLD_CYCLES);
		if (fail_count == 0)
			$display("PASS keyed_value_lookup_insert_table");
		else
			$display("FAIL keyed_value_lookup_insert_table");
		$finish;
	end

endmodule
